// ===== rtl/lfu_cache_lru_tiebreak_macros.svh =====
// Assertion macros for the LFU cache
`ifndef LFU_CACHE_LRU_TIEBREAK_MACROS_SVH
`define LFU_CACHE_LRU_TIEBREAK_MACROS_SVH
`define LFU_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lfu check failed");
`define LFU_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lfu check failed");
`endif

// ===== rtl/lfu_pkg.sv =====
package lfu_pkg;
    localparam int unsigned CAPACITY_DEF   = 16;
    localparam int unsigned COUNT_BITS_DEF = 16;
    localparam int unsigned KEY_W          = 32;
    localparam int unsigned CAP_CFG_W      = 5;
    localparam logic        OP_GET         = 1'b0;
    localparam logic        OP_PUT         = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_DONE
    } lfu_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture item, clear scan state
        logic scan;     // examine current slot
        logic step;     // advance scan pointer
        logic update;   // apply all slot updates
        logic respond;  // drive result strobe
    } lfu_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
    } lfu_status_t;
endpackage

// ===== rtl/lfu_ctrl.sv =====
module lfu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  lfu_pkg::lfu_status_t status,
    output lfu_pkg::lfu_cmd_t   cmd,
    output logic                busy
);
    import lfu_pkg::*;

    lfu_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                cmd.step = 1'b1;
                if (status.scan_last)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
                state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.respond = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/lfu_dp.sv =====
module lfu_dp #(
    parameter int unsigned CAPACITY   = lfu_pkg::CAPACITY_DEF,
    parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lfu_pkg::lfu_cmd_t             cmd,
    output lfu_pkg::lfu_status_t          status,
    input  logic                          cfg_we,
    input  logic [lfu_pkg::CAP_CFG_W-1:0] cfg_wdata,
    input  logic                          op,
    input  logic signed [31:0]            key,
    input  logic signed [31:0]            value,
    output logic                          done,
    output logic                          hit,
    output logic signed [31:0]            read_value
);
    import lfu_pkg::*;

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned OCC_W = $clog2(CAPACITY + 1);
    localparam int unsigned RNK_W = IDX_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // slot state: flops, since every slot's rank is adjusted in parallel
    logic [CAPACITY-1:0]   valid_reg;
    logic [KEY_W-1:0]      key_mem  [CAPACITY];
    logic [31:0]           data_mem [CAPACITY];
    logic [COUNT_BITS-1:0] cnt_mem  [CAPACITY];
    logic [RNK_W-1:0]      rank_mem [CAPACITY];
    logic [OCC_W-1:0]      occ_reg;
    logic [CAP_CFG_W-1:0]  cap_reg;

    logic                  op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [31:0]           val_reg;
    logic [IDX_W-1:0]      ptr_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      found_idx_reg;
    logic                  vic_ok_reg;
    logic [IDX_W-1:0]      vic_idx_reg;
    logic [COUNT_BITS-1:0] vic_cnt_reg;
    logic [RNK_W-1:0]      vic_rank_reg;
    logic                  free_ok_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    logic                  hit_reg;
    logic [31:0]           rv_reg;
    logic                  full_reg;

    logic [OCC_W:0] limit;
    logic           better;

    assign status.scan_last = (ptr_reg == IDX_W'(CAPACITY - 1));
    assign done       = cmd.respond;
    assign hit        = hit_reg;
    assign read_value = rv_reg;

    always_comb
    begin
        if (cap_reg == '0)
            limit = (OCC_W + 1)'(1);
        else if (32'(cap_reg) > CAPACITY)
            limit = (OCC_W + 1)'(CAPACITY);
        else
            limit = (OCC_W + 1)'(cap_reg);
        better = !vic_ok_reg || (cnt_mem[ptr_reg] < vic_cnt_reg) ||
                 ((cnt_mem[ptr_reg] == vic_cnt_reg) && (rank_mem[ptr_reg] > vic_rank_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_CFG_W'(16);
            valid_reg <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (cmd.update && (op_reg == OP_PUT) && !found_reg)
            begin
                if (full_reg && vic_ok_reg)
                    valid_reg[vic_idx_reg] <= 1'b1;
                else if (free_ok_reg)
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                    occ_reg <= occ_reg + OCC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= op;
            key_reg     <= key;
            val_reg     <= value;
            ptr_reg     <= '0;
            found_reg   <= 1'b0;
            vic_ok_reg  <= 1'b0;
            free_ok_reg <= 1'b0;
            full_reg    <= ({1'b0, occ_reg} >= limit);
        end
        if (cmd.scan)
        begin
            if (valid_reg[ptr_reg])
            begin
                if (key_mem[ptr_reg] == key_reg)
                begin
                    found_reg     <= 1'b1;
                    found_idx_reg <= ptr_reg;
                end
                if (better)
                begin
                    vic_ok_reg   <= 1'b1;
                    vic_idx_reg  <= ptr_reg;
                    vic_cnt_reg  <= cnt_mem[ptr_reg];
                    vic_rank_reg <= rank_mem[ptr_reg];
                end
            end
            else if (!free_ok_reg)
            begin
                free_ok_reg  <= 1'b1;
                free_idx_reg <= ptr_reg;
            end
        end
        if (cmd.step && !status.scan_last)
            ptr_reg <= ptr_reg + IDX_W'(1);
        if (cmd.update)
        begin
            hit_reg <= found_reg;
            rv_reg  <= (found_reg && op_reg == OP_GET) ? data_mem[found_idx_reg] : '0;
            if (found_reg)
            begin
                // touch: younger entries age by one, this one becomes newest
                for (int i = 0; i < CAPACITY; i++)
                    if (valid_reg[i] && i != int'(found_idx_reg) &&
                        rank_mem[i] < rank_mem[found_idx_reg])
                        rank_mem[i] <= rank_mem[i] + RNK_W'(1);
                rank_mem[found_idx_reg] <= '0;
                if (cnt_mem[found_idx_reg] != CNT_MAX)
                    cnt_mem[found_idx_reg] <= cnt_mem[found_idx_reg] + COUNT_BITS'(1);
                if (op_reg == OP_PUT)
                    data_mem[found_idx_reg] <= val_reg;
            end
            else if (op_reg == OP_PUT)
            begin
                if (full_reg && vic_ok_reg)
                begin
                    // evict then insert in the same slot: older than victim keep rank
                    for (int i = 0; i < CAPACITY; i++)
                        if (valid_reg[i] && i != int'(vic_idx_reg) &&
                            rank_mem[i] < vic_rank_reg)
                            rank_mem[i] <= rank_mem[i] + RNK_W'(1);
                    key_mem[vic_idx_reg]  <= key_reg;
                    data_mem[vic_idx_reg] <= val_reg;
                    cnt_mem[vic_idx_reg]  <= COUNT_BITS'(1);
                    rank_mem[vic_idx_reg] <= '0;
                end
                else if (free_ok_reg)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                        if (valid_reg[i])
                            rank_mem[i] <= rank_mem[i] + RNK_W'(1);
                    key_mem[free_idx_reg]  <= key_reg;
                    data_mem[free_idx_reg] <= val_reg;
                    cnt_mem[free_idx_reg]  <= COUNT_BITS'(1);
                    rank_mem[free_idx_reg] <= '0;
                end
            end
        end
    end
endmodule

// ===== rtl/lfu_cache_lru_tiebreak.sv =====
// LFU key/value cache, least recently touched entry loses a count tie.
// Input channel: op, key, value, taken at a rising edge with start high and
// busy low. busy stays high until the result has been shown.
// Result channel: done pulses for one cycle with hit and read_value; the
// receiver must take it then, it cannot stall the block.
// Configuration: cap_we/cap_wdata write active_capacity (0 acts as 1, above
// CAPACITY acts as CAPACITY); write only while busy is low.
// Sequence: after accept the scan examines one slot per cycle for key match,
// victim and free slot; then come the decide, update and done states. One
// item at a time, so the next item can be taken only once done has been shown.
// The update state applies the update to all slot ranks at once.
// Reset empties the cache and sets active_capacity to 16; no clearing pass.
module lfu_cache_lru_tiebreak #(
    parameter int unsigned CAPACITY   = lfu_pkg::CAPACITY_DEF,
    parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cap_we,
    input  logic [lfu_pkg::CAP_CFG_W-1:0] cap_wdata,
    input  logic                          op,
    input  logic signed [31:0]            key,
    input  logic signed [31:0]            value,
    output logic                          done,
    output logic                          hit,
    output logic signed [31:0]            read_value
);
    import lfu_pkg::*;
    `include "lfu_cache_lru_tiebreak_macros.svh"

    lfu_cmd_t    cmd;
    lfu_status_t status;

    lfu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    lfu_dp #(
        .CAPACITY   (CAPACITY),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cap_we),
        .cfg_wdata  (cap_wdata),
        .op         (op),
        .key        (key),
        .value      (value),
        .done       (done),
        .hit        (hit),
        .read_value (read_value)
    );

    // result only while busy, and busy drops right after it
    `LFU_ASSERT_IMP(a_done_busy, clk, rst_n, done, busy)
    `LFU_ASSERT_NEXT(a_done_frees, clk, rst_n, done, !busy)
    // accepted item makes block busy next cycle
    `LFU_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)
endmodule

// ===== dv/lfu_cache_checker.sv =====
`timescale 1ns / 1ps

module lfu_cache_checker
    import lfu_pkg::*;
#(
    parameter int unsigned CAPACITY   = CAPACITY_DEF,
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               cap_we,
    input  logic [CAP_CFG_W-1:0] cap_wdata,
    input  logic               op,
    input  logic signed [31:0] key,
    input  logic signed [31:0] value,
    input  logic               done,
    input  logic               hit,
    input  logic signed [31:0] read_value,
    output int                 fail_count,
    output int                 pending
);
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

    typedef struct {
        logic        hit;
        logic [31:0] rdata;
    } lookup_t;

    lookup_t lookup_q[$];

    logic [CAP_CFG_W-1:0]  cap_reg;
    logic                  slot_live [CAPACITY];
    logic [31:0]           slot_key  [CAPACITY];
    logic [31:0]           slot_data [CAPACITY];
    logic [COUNT_BITS-1:0] slot_uses [CAPACITY];
    int unsigned           slot_age  [CAPACITY];
    int unsigned           n_live;

    assign pending = lookup_q.size();

    task automatic report(input string what);
        fail_count++;
        $display("mismatch: %s", what);
    endtask

    function automatic int unsigned cap_limit();
        int unsigned c;
        c = cap_reg;
        if (c < 1) c = 1;
        if (c > CAPACITY) c = CAPACITY;
        return c;
    endfunction

    // bring slot s to age 0, shifting younger entries up by one
    task automatic promote(input int s);
        for (int i = 0; i < CAPACITY; i++)
            if (slot_live[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
        slot_age[s] = 0;
    endtask

    task automatic bump(input int s);
        if (slot_uses[s] != COUNT_TOP) slot_uses[s]++;
        promote(s);
    endtask

    function automatic int evict_lfu();
        int v;
        v = -1;
        for (int i = 0; i < CAPACITY; i++) begin
            if (!slot_live[i]) continue;
            if (v < 0 || slot_uses[i] < slot_uses[v] ||
                (slot_uses[i] == slot_uses[v] && slot_age[i] > slot_age[v]))
                v = i;
        end
        if (v >= 0) begin
            for (int i = 0; i < CAPACITY; i++)
                if (slot_live[i] && slot_age[i] > slot_age[v]) slot_age[i]--;
            slot_live[v] = 1'b0;
            n_live--;
        end
        return v;
    endfunction

    task automatic apply_access(input logic is_put, input logic [31:0] k,
                                input logic [31:0] d);
        int s;
        lookup_t exp_r;
        s = -1;
        for (int i = 0; i < CAPACITY; i++)
            if (s < 0 && slot_live[i] && slot_key[i] == k) s = i;
        exp_r.hit   = (s >= 0);
        exp_r.rdata = '0;
        if (s >= 0) begin
            if (is_put == OP_PUT) slot_data[s] = d;
            else exp_r.rdata = slot_data[s];
            bump(s);
        end else if (is_put == OP_PUT) begin
            if (n_live >= cap_limit()) s = evict_lfu();
            if (s < 0)
                for (int i = CAPACITY - 1; i >= 0; i--)
                    if (!slot_live[i]) s = i;
            if (s >= 0) begin
                for (int i = 0; i < CAPACITY; i++)
                    if (slot_live[i]) slot_age[i]++;
                slot_live[s] = 1'b1;
                slot_key[s]  = k;
                slot_data[s] = d;
                slot_uses[s] = 1;
                slot_age[s]  = 0;
                n_live++;
            end
        end
        lookup_q.push_back(exp_r);
    endtask

    always @(posedge clk or negedge rst_n) begin
        lookup_t e;
        if (!rst_n) begin
            cap_reg    <= 5'd16;
            fail_count <= 0;
            n_live     = 0;
            lookup_q.delete();
            for (int i = 0; i < CAPACITY; i++) slot_live[i] = 1'b0;
        end else begin
            if (done) begin
                if (lookup_q.size() == 0) begin
                    report("result with nothing outstanding");
                end else begin
                    e = lookup_q.pop_front();
                    if (hit !== e.hit)
                        report($sformatf("hit %b, want %b", hit, e.hit));
                    if (read_value !== e.rdata)
                        report($sformatf("read_value %h, want %h", read_value, e.rdata));
                end
            end
            if (cap_we) cap_reg <= cap_wdata;
            if (start && !busy) apply_access(op, key, value);
        end
    end
endmodule

// ===== dv/tb_lfu_cache_lru_tiebreak.sv =====
`timescale 1ns / 1ps

module tb_lfu_cache_lru_tiebreak;
    import lfu_pkg::*;

    localparam int CAP       = 16;
    localparam int LATENCY   = CAP + 4;
    localparam int CYCLE_CAP = 400000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 cap_we;
    logic [CAP_CFG_W-1:0] cap_wdata;
    logic                 op;
    logic signed [31:0]   key;
    logic signed [31:0]   value;
    logic                 done;
    logic                 hit;
    logic signed [31:0]   read_value;
    int                   fail_count;
    int                   pending;
    int                   cycles = 0;

    // small key pool so gets hit and puts collide; some fully random keys too
    logic [31:0] key_pool [8];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = 1'b1;
            #2 clk = 1'b0;
        end
    end

    lfu_cache_lru_tiebreak dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cap_we(cap_we), .cap_wdata(cap_wdata),
        .op(op), .key(key), .value(value),
        .done(done), .hit(hit), .read_value(read_value)
    );

    lfu_cache_checker #(.CAPACITY(CAP)) u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cap_we(cap_we), .cap_wdata(cap_wdata),
        .op(op), .key(key), .value(value),
        .done(done), .hit(hit), .read_value(read_value),
        .fail_count(fail_count), .pending(pending)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // present one item, hold start until accepted, then a random gap if gaps is set
    task automatic send_item(input logic o, input logic [31:0] k, input logic [31:0] d,
                             input bit gaps);
        int gap;
        start <= 1'b1;
        op    <= o;
        key   <= k;
        value <= d;
        @(posedge clk);
        while (busy) @(posedge clk);
        gap = gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // idle the block and wait for all results before a register write
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_cap(input logic [CAP_CFG_W-1:0] c);
        drain();
        cap_we    <= 1'b1;
        cap_wdata <= c;
        @(posedge clk);
        cap_we    <= 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return key_pool[$urandom_range(0, 7)];
    endfunction

    task automatic random_phase(input int n, input bit gaps);
        for (int i = 0; i < n; i++)
            send_item(1'($urandom_range(0, 1)), pick_key(), $urandom,
                      gaps && $urandom_range(0, 3) != 0);
    endtask

    initial
    begin
        logic [CAP_CFG_W-1:0] caps [6];
        rst_n     = 1'b0;
        start     = 1'b0;
        cap_we    = 1'b0;
        cap_wdata = '0;
        op        = OP_GET;
        key       = '0;
        value     = '0;
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-cache miss, extremes, update, hit
        send_item(OP_GET, 32'h0000_0000, 32'hffff_ffff, 1'b0);
        send_item(OP_PUT, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_item(OP_PUT, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
        send_item(OP_PUT, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        send_item(OP_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_item(OP_GET, 32'h8000_0000, 32'h0, 1'b0);
        send_item(OP_PUT, 32'h7fff_ffff, 32'h1234_5678, 1'b0);
        send_item(OP_GET, 32'h7fff_ffff, 32'hffff_ffff, 1'b1);
        send_item(OP_GET, 32'h1111_1111, 32'h0, 1'b0);

        // capacity zero acts as one: every new put evicts the least frequently used entry
        write_cap(5'd0);
        send_item(OP_PUT, 32'h0000_00a0, 32'h5555_aaaa, 1'b0);
        send_item(OP_PUT, 32'h0000_00a1, 32'haaaa_5555, 1'b0);
        send_item(OP_GET, 32'h0000_00a0, 32'h0, 1'b0);
        send_item(OP_GET, 32'h0000_00a1, 32'h0, 1'b0);

        // capacity two: tie on count goes to the least recently touched
        write_cap(5'd2);
        send_item(OP_PUT, 32'h0000_00b0, 32'h1, 1'b0);
        send_item(OP_PUT, 32'h0000_00b1, 32'h2, 1'b0);
        send_item(OP_PUT, 32'h0000_00b2, 32'h3, 1'b0);
        send_item(OP_GET, 32'h0000_00b0, 32'h0, 1'b0);
        send_item(OP_GET, 32'h0000_00b1, 32'h0, 1'b0);

        // above the physical size acts as the full size
        write_cap(5'd31);
        for (int i = 0; i < 18; i++)
            send_item(OP_PUT, 32'h0000_0c00 + i, $urandom, 1'b0);

        // random phases under varying capacity, lowering below occupancy too
        caps = '{5'd16, 5'd3, 5'd1, 5'd8, 5'd31, 5'd0};
        for (int p = 0; p < 6; p++)
        begin
            write_cap(caps[p]);
            random_phase(150, 1'b1);
            // pause until every result is in, then a burst with no idling
            drain();
            random_phase(25, 1'b0);
        end

        drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lfu_pkg.sv
rtl/lfu_ctrl.sv
rtl/lfu_dp.sv
rtl/lfu_cache_lru_tiebreak.sv
dv/lfu_cache_checker.sv
dv/tb_lfu_cache_lru_tiebreak.sv
